>>> src/gcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcw_pkg
// Shared widths, constants, types and the base weight table for the
// windowed G+C content unit.
// ----------------------------------------------------------------------------
package gcw_pkg;

	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 13;
	localparam int SUM_W       = 19;
	localparam int FRAC_W      = 17;
	localparam int QUO_W       = 16;
	localparam int WEIGHT_W    = 7;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;
	localparam int ITER_W      = 4;

	localparam logic [LEN_W-1:0]  MAX_WINDOW  = 13'd4096;
	localparam logic [LEN_W-1:0]  LEN_RESET   = 13'd100;
	localparam logic [SUM_W-1:0]  DENOM_SCALE = 19'd100;
	localparam logic [FRAC_W-1:0] FRAC_ONE    = 17'h10000;
	localparam logic [CHAR_W-1:0] GAP_CHAR    = 8'h2D;
	localparam logic [ITER_W-1:0] ITER_LAST   = 4'd15;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] denom;
		logic             gap;
	} win_t;

	function automatic logic [WEIGHT_W-1:0] base_weight(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0]   u;
		logic [WEIGHT_W-1:0] w;
		u = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			u = c - 8'd32;
		end
		case (u)
			8'h47, 8'h43, 8'h53:        w = 7'd100;
			8'h4D, 8'h52, 8'h59, 8'h4B: w = 7'd50;
			8'h56, 8'h42:               w = 7'd68;
			8'h48, 8'h44:               w = 7'd34;
			8'h41, 8'h54, 8'h57, 8'h2D: w = 7'd0;
			default:                    w = 7'd50;
		endcase
		return w;
	endfunction

endpackage

>>> src/gcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcw_front
// Holds the window length register, accumulates weights per character and
// hands each closed window to the queue.
// ----------------------------------------------------------------------------
module gcw_front import gcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [LEN_W-1:0]  cfg_len,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] base_char,
	output logic              push,
	output win_t              push_win,
	input  logic              q_full
);

	logic [LEN_W-1:0]  window_len_q;
	logic [SUM_W-1:0]  sum_q;
	logic [LEN_W-1:0]  seen_q;
	logic              gap_q;
	logic [LEN_W-1:0]  len_eff;
	logic [LEN_W-1:0]  seen_next;
	logic [SUM_W-1:0]  sum_next;
	logic              gap_next;
	logic              close;
	logic              accept;

	always_comb begin
		len_eff = window_len_q;
		if (window_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (window_len_q > MAX_WINDOW) begin
			len_eff = MAX_WINDOW;
		end
	end

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign seen_next = seen_q + LEN_W'(1);
	assign sum_next  = sum_q + SUM_W'(base_weight(base_char));
	assign gap_next  = gap_q || (base_char == GAP_CHAR);
	assign close     = seen_next >= len_eff;

	assign push           = accept && close;
	assign push_win.sum   = sum_next;
	assign push_win.denom = SUM_W'({{(SUM_W-LEN_W){1'b0}}, len_eff} * DENOM_SCALE);
	assign push_win.gap   = gap_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_RESET;
			sum_q        <= '0;
			seen_q       <= '0;
			gap_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				window_len_q <= cfg_len;
			end
			if (accept) begin
				if (close) begin
					sum_q  <= '0;
					seen_q <= '0;
					gap_q  <= 1'b0;
				end else begin
					sum_q  <= sum_next;
					seen_q <= seen_next;
					gap_q  <= gap_next;
				end
			end
		end
	end

endmodule

>>> src/gcw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcw_queue
// Short first-in first-out queue of closed windows between the front and
// the divider.
// ----------------------------------------------------------------------------
module gcw_queue import gcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  win_t              push_win,
	input  logic              pop,
	output win_t              head_win,
	output logic              full,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	win_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = cnt_q == QCNT_W'(QDEPTH);
	assign empty    = cnt_q == '0;
	assign count    = cnt_q;
	assign head_win = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> src/gcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcw_back
// Takes closed windows from the queue, forms the fraction with a radix-2
// restoring divider and drives the result channel.
// ----------------------------------------------------------------------------
module gcw_back import gcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  win_t              head_win,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [FRAC_W-1:0] gc_fraction,
	output logic              gap_error
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  denom_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ITER_W-1:0] iter_q;
	logic [FRAC_W-1:0] res_q;
	logic              res_gap_q;
	logic              out_valid_q;
	logic [FRAC_W-1:0] frac_q;
	logic              gap_err_q;
	logic [SUM_W:0]    rem_sh;
	logic              fits;
	logic [SUM_W-1:0]  rem_new;
	logic              slot_free;

	assign rem_sh    = {rem_q, 1'b0};
	assign fits      = rem_sh >= {1'b0, denom_q};
	assign rem_new   = fits ? SUM_W'(rem_sh - {1'b0, denom_q}) : rem_sh[SUM_W-1:0];
	assign slot_free = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && !q_empty;

	assign out_valid   = out_valid_q;
	assign gc_fraction = frac_q;
	assign gap_error   = gap_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			iter_q      <= '0;
			rem_q       <= '0;
			denom_q     <= '0;
			quo_q       <= '0;
			res_q       <= '0;
			res_gap_q   <= 1'b0;
			frac_q      <= '0;
			gap_err_q   <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						res_gap_q <= head_win.gap;
						rem_q     <= head_win.sum;
						denom_q   <= head_win.denom;
						quo_q     <= '0;
						iter_q    <= '0;
						if (head_win.gap) begin
							res_q   <= '0;
							state_q <= ST_FIN;
						end else if (head_win.sum >= head_win.denom) begin
							res_q   <= FRAC_ONE;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q  <= rem_new;
					quo_q  <= {quo_q[QUO_W-2:0], fits};
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_LAST) begin
						res_q   <= {1'b0, quo_q[QUO_W-2:0], fits};
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						frac_q    <= res_q;
						gap_err_q <= res_gap_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/gc_content_window_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gc_content_window_unit
// Streaming G+C content over windows of a programmable number of characters.
// ----------------------------------------------------------------------------
// One ASCII nucleotide or ambiguity code is taken per transfer on the input
// channel (in_valid, in_ready, base_char). Every window_len characters, one
// result transfer follows on the output channel (out_valid, out_ready,
// gc_fraction, gap_error), where gc_fraction is the G+C share scaled so that
// 65536 is 1.0, and gap_error flags a gap character in that window, with the
// fraction forced to 0. The window length is written through the cfg_valid,
// cfg_ready and window_len port, which is always ready and is meant to be
// used while the unit is idle. A length of 0 acts as 1, one above 4096 as
// 4096.
// The front accepts one character per cycle while the two-entry window queue
// has room. A closed window with a gap or a full fraction skips the divider,
// any other runs through the restoring divider first; either way the result
// register is then loaded from the result stage. Short windows are thus
// limited by the divider, which takes a new window only once it is idle again.
// Reset clears the sums, the queue and the result register and sets the
// length to 100. A stalled receiver holds the result; the queue then fills
// and in_ready drops.
// ----------------------------------------------------------------------------
module gc_content_window_unit import gcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [LEN_W-1:0]  window_len,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] base_char,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [FRAC_W-1:0] gc_fraction,
	output logic              gap_error
);

	logic              push;
	win_t              push_win;
	logic              pop;
	win_t              head_win;
	logic              q_full;
	logic              q_empty;
	logic [QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	gcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_len   (window_len),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.base_char (base_char),
		.push      (push),
		.push_win  (push_win),
		.q_full    (q_full)
	);

	gcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_win (push_win),
		.pop      (pop),
		.head_win (head_win),
		.full     (q_full),
		.empty    (q_empty),
		.count    (q_count)
	);

	gcw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_win    (head_win),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.gc_fraction (gc_fraction),
		.gap_error   (gap_error)
	);

`ifndef NO_ASSERTIONS
	a_gap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gap_error |-> gc_fraction == '0)
		else $error("gap window reported a nonzero fraction");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gc_fraction <= FRAC_ONE)
		else $error("fraction above 1.0");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH) && !(q_full && push && !pop))
		else $error("window queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("window queue read while empty");
`endif

endmodule
